[design/pic_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg
// Types and constants shared by the interrupt controller files.
// ----------------------------------------------------------------------------
package pic_pkg;

    // event codes
    localparam logic [2:0] CMD_RAISE = 3'd0;
    localparam logic [2:0] CMD_DROP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_ACK   = 3'd4;

    // OCW2 command codes, bits 7..5
    localparam logic [2:0] OCW2_EOI_NONSPEC = 3'd1;
    localparam logic [2:0] OCW2_EOI_SPEC    = 3'd3;
    localparam logic [2:0] OCW2_SET_PRIO    = 3'd6;

    // bit positions in the command words
    localparam int ICW1_START_BIT  = 4;
    localparam int ICW1_SINGLE_BIT = 1;
    localparam int ICW1_NEED4_BIT  = 0;
    localparam int ICW4_X86_BIT    = 0;
    localparam int OCW3_SEL_BIT    = 3;
    localparam int OCW3_RR_BIT     = 1;
    localparam int OCW3_RIS_BIT    = 0;

    localparam logic [7:0] VEC_BASE_MASK  = 8'hF8;
    localparam logic [2:0] SPURIOUS_LINE  = 3'd7;
    localparam logic [7:0] MASK_RESET     = 8'hFF;
    localparam logic [2:0] LOWEST_RESET   = 3'd7;

    typedef enum logic [2:0] {
        PHASE_ICW1 = 3'd0,
        PHASE_ICW2 = 3'd1,
        PHASE_ICW3 = 3'd2,
        PHASE_ICW4 = 3'd3,
        PHASE_OPER = 3'd4
    } phase_t;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] line;
        logic       port_offset;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       int_pending;
    } result_t;

endpackage

[design/pic_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_item_if / pic_result_if
// Valid/ready channels for controller events and their results.
// ----------------------------------------------------------------------------
interface pic_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [2:0] line;
    logic       port_offset;
    logic [7:0] write_data;

    modport source (output valid, command, line, port_offset, write_data, input ready);
    modport sink   (input valid, command, line, port_offset, write_data, output ready);
endinterface

interface pic_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] vector;
    logic       int_pending;

    modport source (output valid, read_data, vector, int_pending, input ready);
    modport sink   (input valid, read_data, vector, int_pending, output ready);
endinterface

[design/pic_prio_enc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_prio_enc
// Rotating priority encoder: first set bit at or after the line just above
// the lowest-priority line, wrapping from 7 to 0.
// ----------------------------------------------------------------------------
module pic_prio_enc
(
    input  logic [7:0] bits,
    input  logic [2:0] lowest,
    output logic       found,
    output logic [2:0] line
);

    logic [2:0]  start;
    logic [15:0] doubled;
    logic [7:0]  rotated;
    logic [2:0]  offset;

    assign start   = lowest + 3'd1;
    assign doubled = {bits, bits} >> start;
    assign rotated = doubled[7:0];
    assign found   = |bits;

    always_comb
    begin
        offset = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (rotated[i])
            begin
                offset = 3'(i);
            end
        end
    end

    assign line = start + offset;

endmodule

[design/pic_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_core
// Controller registers and the single-pass update for one event.
// ----------------------------------------------------------------------------
module pic_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  pic_pkg::item_t   item,
    output pic_pkg::result_t res
);

    logic [7:0]      request_reg,  request_next;
    logic [7:0]      mask_reg,     mask_next;
    logic [7:0]      in_service_reg, in_service_next;
    logic [7:0]      icw1_reg,     icw1_next;
    logic [7:0]      vec_base_reg, vec_base_next;
    logic [7:0]      cascade_reg,  cascade_next;
    logic [7:0]      mode_reg,     mode_next;
    pic_pkg::phase_t phase_reg,    phase_next;
    logic            ris_reg,      ris_next;
    logic [2:0]      lowest_reg,   lowest_next;

    logic [7:0] pending;
    logic       pend_found;
    logic [2:0] pend_line;
    logic       isr_found;
    logic [2:0] isr_line;
    logic [7:0] base;
    pic_pkg::phase_t after_icw3;

    assign pending = request_reg & ~mask_reg;
    assign base    = vec_base_reg & pic_pkg::VEC_BASE_MASK;

    pic_prio_enc u_pend_enc
    (
        .bits   (pending),
        .lowest (lowest_reg),
        .found  (pend_found),
        .line   (pend_line)
    );

    pic_prio_enc u_isr_enc
    (
        .bits   (in_service_reg),
        .lowest (lowest_reg),
        .found  (isr_found),
        .line   (isr_line)
    );

    assign after_icw3 = icw1_reg[pic_pkg::ICW1_NEED4_BIT] ? pic_pkg::PHASE_ICW4
                                                          : pic_pkg::PHASE_OPER;

    always_comb
    begin
        request_next    = request_reg;
        mask_next       = mask_reg;
        in_service_next = in_service_reg;
        icw1_next       = icw1_reg;
        vec_base_next   = vec_base_reg;
        cascade_next    = cascade_reg;
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        ris_next        = ris_reg;
        lowest_next     = lowest_reg;
        res.read_data   = 8'd0;
        res.vector      = 8'd0;

        case (item.command)
            pic_pkg::CMD_RAISE:
            begin
                request_next = request_reg | (8'd1 << item.line);
            end
            pic_pkg::CMD_DROP:
            begin
                request_next = request_reg & ~(8'd1 << item.line);
            end
            pic_pkg::CMD_WRITE:
            begin
                if (item.port_offset)
                begin
                    case (phase_reg)
                        pic_pkg::PHASE_ICW2:
                        begin
                            vec_base_next = item.write_data;
                            if (icw1_reg[pic_pkg::ICW1_SINGLE_BIT])
                            begin
                                phase_next = after_icw3;
                            end
                            else
                            begin
                                phase_next = pic_pkg::PHASE_ICW3;
                            end
                        end
                        pic_pkg::PHASE_ICW3:
                        begin
                            cascade_next = item.write_data;
                            phase_next   = after_icw3;
                        end
                        pic_pkg::PHASE_ICW4:
                        begin
                            mode_next  = item.write_data;
                            phase_next = pic_pkg::PHASE_OPER;
                        end
                        pic_pkg::PHASE_OPER:
                        begin
                            mask_next = item.write_data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (item.write_data[pic_pkg::ICW1_START_BIT])
                begin
                    icw1_next  = item.write_data;
                    phase_next = pic_pkg::PHASE_ICW2;
                end
                else if (item.write_data[pic_pkg::OCW3_SEL_BIT])
                begin
                    if (item.write_data[pic_pkg::OCW3_RR_BIT])
                    begin
                        ris_next = item.write_data[pic_pkg::OCW3_RIS_BIT];
                    end
                end
                else
                begin
                    case (item.write_data[7:5])
                        pic_pkg::OCW2_EOI_NONSPEC:
                        begin
                            if (isr_found)
                            begin
                                in_service_next = in_service_reg & ~(8'd1 << isr_line);
                            end
                        end
                        pic_pkg::OCW2_EOI_SPEC:
                        begin
                            in_service_next = in_service_reg
                                              & ~(8'd1 << item.write_data[2:0]);
                        end
                        pic_pkg::OCW2_SET_PRIO:
                        begin
                            lowest_next = item.write_data[2:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pic_pkg::CMD_READ:
            begin
                if (item.port_offset)
                begin
                    res.read_data = mask_reg;
                end
                else if (in_service_reg != 8'd0)
                begin
                    res.read_data = in_service_reg;
                end
                else
                begin
                    res.read_data = request_reg;
                end
            end
            pic_pkg::CMD_ACK:
            begin
                res.vector = base | {5'd0, pic_pkg::SPURIOUS_LINE};
                if (pend_found)
                begin
                    request_next    = request_reg & ~(8'd1 << pend_line);
                    in_service_next = in_service_reg | (8'd1 << pend_line);
                    if (mode_reg[pic_pkg::ICW4_X86_BIT])
                    begin
                        res.vector = base | {5'd0, pend_line};
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.int_pending = |(request_next & ~mask_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_reg    <= 8'd0;
            mask_reg       <= pic_pkg::MASK_RESET;
            in_service_reg <= 8'd0;
            icw1_reg       <= 8'd0;
            vec_base_reg   <= 8'd0;
            cascade_reg    <= 8'd0;
            mode_reg       <= 8'd0;
            phase_reg      <= pic_pkg::PHASE_ICW1;
            ris_reg        <= 1'b0;
            lowest_reg     <= pic_pkg::LOWEST_RESET;
        end
        else if (en)
        begin
            request_reg    <= request_next;
            mask_reg       <= mask_next;
            in_service_reg <= in_service_next;
            icw1_reg       <= icw1_next;
            vec_base_reg   <= vec_base_next;
            cascade_reg    <= cascade_next;
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            ris_reg        <= ris_next;
            lowest_reg     <= lowest_next;
        end
    end

endmodule

[design/interrupt_controller_8259.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_controller_8259
// Single 8259-style interrupt controller, one event in, one result out.
// ----------------------------------------------------------------------------
// result path: the event goes into the input register, then into the result
//   register, which offers it on the result side as valid
// throughput: one event per cycle while the result side keeps taking
// reset: rst_n clears both stages and the controller registers at once
//   (mask all set, lowest-priority line seven, awaiting ICW1)
module interrupt_controller_8259
(
    input  logic         clk,
    input  logic         rst_n,
    pic_item_if.sink     item,
    pic_result_if.source result
);

    logic              in_valid_reg;
    pic_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    pic_pkg::result_t  out_res_reg;
    pic_pkg::result_t  core_res;
    logic              advance;

    // the input stage moves on whenever the result register is free or drains
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_item_reg.command     <= item.command;
            in_item_reg.line        <= item.line;
            in_item_reg.port_offset <= item.port_offset;
            in_item_reg.write_data  <= item.write_data;
        end
    end

    pic_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (in_item_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.read_data   = out_res_reg.read_data;
    assign result.vector      = out_res_reg.vector;
    assign result.int_pending = out_res_reg.int_pending;

endmodule

[design/pic_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks on the interrupt controller's channels.
// ----------------------------------------------------------------------------
module pic_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] result_read_data,
    input logic [7:0] result_vector,
    input logic       result_int_pending
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_read_data) && $stable(result_vector)
            && $stable(result_int_pending))
        else $error("result payload changed while stalled");

    // only a read gives read data and only an acknowledge gives a vector
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_read_data == 8'd0 || result_vector == 8'd0))
        else $error("read data and vector both nonzero");

    // a transfer reaches the result side through the input and result registers when nothing stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && result_ready) ##1 result_ready |=> result_valid)
        else $error("result missing after event transfer");

endmodule

bind interrupt_controller_8259 pic_checker u_pic_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_read_data   (result.read_data),
    .result_vector      (result.vector),
    .result_int_pending (result.int_pending)
);
